// ===== src/ipc_pkg.sv =====
// shared constants for the iteration palette color block
package ipc_pkg;

    // default parameter values
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // port widths fixed by the field definitions
    localparam int COUNT_W = 16;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int ORDER_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

    // register reset values
    localparam logic [COUNT_W-1:0] LIMIT_RST = 16'd100;
    localparam logic [ORDER_W-1:0] ORDER_RST = 3'd0;

    // channel order codes, high byte first
    localparam logic [ORDER_W-1:0] ORDER_RGB = 3'd0;
    localparam logic [ORDER_W-1:0] ORDER_GBR = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_BRG = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_RBG = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_GRB = 3'd4;
    localparam logic [ORDER_W-1:0] ORDER_BGR = 3'd5;

    // channel weights: 9*255, 15*255, 2*8.5*255
    localparam int COEF_W = 13;
    localparam logic [COEF_W-1:0] COEF_RED   = 13'd2295;
    localparam logic [COEF_W-1:0] COEF_GREEN = 13'd3825;
    localparam logic [COEF_W-1:0] COEF_BLUE  = 13'd4335;

endpackage

// ===== src/iteration_palette_color.sv =====
// top level of the iteration palette color block
// Maps one escape-iteration count per pixel to a 24-bit palette color.
// Input: a transfer happens at each clock edge with start high and busy low;
// busy is always low, so a new count may enter in every cycle.
// Output: o_valid is high for exactly one cycle with o_pixel_color; the
// receiver takes it in that cycle and cannot hold it off.
// Pipeline: an entry register, then the divider, which spends one stage per
// quotient bit (FRAC_BITS + 1 stages), then four polynomial stages and the
// packing register.
// Throughput: one pixel per cycle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 iteration limit, 1 channel order); write only when the pipeline is empty.
// Reset: clears the pipeline valid bits and loads limit 100, order rgb.
module iteration_palette_color #(
    parameter int COUNT_BITS = ipc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ipc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ipc_pkg::COUNT_W-1:0]   i_iteration_count,
    output logic                          o_valid,
    output logic [ipc_pkg::COLOR_W-1:0]   o_pixel_color,
    input  logic                          i_cfg_we,
    input  logic [ipc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int CW = (COUNT_BITS < ipc_pkg::COUNT_W) ? COUNT_BITS : ipc_pkg::COUNT_W;

    logic [ipc_pkg::COUNT_W-1:0] r_limit;
    logic [ipc_pkg::ORDER_W-1:0] r_order;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ipc_pkg::LIMIT_RST;
            r_order <= ipc_pkg::ORDER_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ipc_pkg::REG_LIMIT) begin
                r_limit <= i_cfg_data;
            end else if (i_cfg_index == ipc_pkg::REG_ORDER) begin
                r_order <= i_cfg_data[ipc_pkg::ORDER_W-1:0];
            end
        end
    end

    assign busy = 1'b0;

    // division into fixed-point t
    logic          div_vld;
    logic [FRAC_BITS:0] div_t;

    ipc_div #(
        .CW (CW),
        .F  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_count (i_iteration_count[CW-1:0]),
        .i_limit (r_limit[CW-1:0]),
        .o_vld   (div_vld),
        .o_t     (div_t)
    );

    // channel polynomials
    logic       poly_vld;
    logic [7:0] red, green, blue;

    ipc_poly #(
        .F (FRAC_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_t     (div_t),
        .o_vld   (poly_vld),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    // channel packing
    logic [ipc_pkg::COLOR_W-1:0] n_color;
    logic [ipc_pkg::COLOR_W-1:0] r_color;
    logic                        r_valid;

    always_comb begin
        case (r_order)
            ipc_pkg::ORDER_GBR: n_color = {green, blue, red};
            ipc_pkg::ORDER_BRG: n_color = {blue, red, green};
            ipc_pkg::ORDER_RBG: n_color = {red, blue, green};
            ipc_pkg::ORDER_GRB: n_color = {green, red, blue};
            ipc_pkg::ORDER_BGR: n_color = {blue, green, red};
            default:            n_color = {red, green, blue};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= poly_vld;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_color = r_color;

endmodule

// ===== src/ipc_div.sv =====
// pipelined restoring divider forming t = (count << F) / limit
module ipc_div #(
    parameter int CW = 16,
    parameter int F  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_limit,
    output logic          o_vld,
    output logic [F:0]    o_t
);
    localparam int NS = F + 1;

    logic          r_vld [0:NS];
    logic [CW-1:0] r_rem [0:NS];
    logic [F:0]    r_q   [0:NS];
    logic [CW-1:0] n_sat;

    // saturate the count to the limit on entry
    assign n_sat = (i_count > i_limit) ? i_limit : i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_sat;
        r_q[0]   <= '0;
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [CW:0] d;
        logic [CW:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign d = {1'b0, r_rem[k]};
        end else begin : g_rest
            assign d = {r_rem[k], 1'b0};
        end

        assign ge   = (d >= {1'b0, i_limit});
        assign diff = d - {1'b0, i_limit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[CW-1:0] : d[CW-1:0];
            r_q[k+1]   <= {r_q[k][F-1:0], ge};
        end
    end

    // a zero limit maps every count to black
    assign o_vld = r_vld[NS];
    assign o_t   = (i_limit == '0) ? '0 : r_q[NS];

endmodule

// ===== src/ipc_poly.sv =====
// pipelined bernstein polynomial evaluation of the three channels
module ipc_poly #(
    parameter int F = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  logic [F:0] i_t,
    output logic       o_vld,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    localparam int PW = 2 * F + 2;
    localparam int CPW = F + 1 + ipc_pkg::COEF_W;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [3:0] r_vld;

    // stage a: squares
    logic [F:0]    n_u;
    logic [PW-1:0] n_tt, n_uu;
    logic [F:0]    r_a_t, r_a_u, r_a_t2, r_a_u2;

    assign n_u  = ONE - i_t;
    assign n_tt = PW'(i_t) * PW'(i_t);
    assign n_uu = PW'(n_u) * PW'(n_u);

    always_ff @(posedge i_clk) begin
        r_a_t  <= i_t;
        r_a_u  <= n_u;
        r_a_t2 <= n_tt[2*F:F];
        r_a_u2 <= n_uu[2*F:F];
    end

    // stage b: cubes
    logic [PW-1:0] n_ttt, n_uuu;
    logic [F:0]    r_b_t, r_b_u, r_b_t2, r_b_u2, r_b_t3, r_b_u3;

    assign n_ttt = PW'(r_a_t2) * PW'(r_a_t);
    assign n_uuu = PW'(r_a_u2) * PW'(r_a_u);

    always_ff @(posedge i_clk) begin
        r_b_t  <= r_a_t;
        r_b_u  <= r_a_u;
        r_b_t2 <= r_a_t2;
        r_b_u2 <= r_a_u2;
        r_b_t3 <= n_ttt[2*F:F];
        r_b_u3 <= n_uuu[2*F:F];
    end

    // stage c: basis products
    logic [PW-1:0] n_pr, n_pg, n_pb;
    logic [F:0]    r_c_pr, r_c_pg, r_c_pb;

    assign n_pr = PW'(r_b_u) * PW'(r_b_t3);
    assign n_pg = PW'(r_b_u2) * PW'(r_b_t2);
    assign n_pb = PW'(r_b_u3) * PW'(r_b_t);

    always_ff @(posedge i_clk) begin
        r_c_pr <= n_pr[2*F:F];
        r_c_pg <= n_pg[2*F:F];
        r_c_pb <= n_pb[2*F:F];
    end

    // stage d: weight, truncate and clamp
    logic [CPW-1:0] n_wr, n_wg, n_wb;
    logic [CPW-F-1:0] n_sr, n_sg;
    logic [CPW-F-2:0] n_sb;
    logic [7:0] r_red, r_green, r_blue;

    assign n_wr = CPW'(r_c_pr) * CPW'(ipc_pkg::COEF_RED);
    assign n_wg = CPW'(r_c_pg) * CPW'(ipc_pkg::COEF_GREEN);
    assign n_wb = CPW'(r_c_pb) * CPW'(ipc_pkg::COEF_BLUE);
    assign n_sr = n_wr[CPW-1:F];
    assign n_sg = n_wg[CPW-1:F];
    assign n_sb = n_wb[CPW-1:F+1];

    always_ff @(posedge i_clk) begin
        r_red   <= (|n_sr[CPW-F-1:8]) ? 8'hFF : n_sr[7:0];
        r_green <= (|n_sg[CPW-F-1:8]) ? 8'hFF : n_sg[7:0];
        r_blue  <= (|n_sb[CPW-F-2:8]) ? 8'hFF : n_sb[7:0];
    end

    // valid bits follow the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign o_vld   = r_vld[3];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== tb/sv/tb_iteration_palette_color.sv =====
// self-checking testbench for the iteration palette color block
module tb_iteration_palette_color;
    import ipc_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LATENCY   = FRAC + 7;
    localparam int IDLE_MAX  = 2000;
    localparam int SHOW_MAX  = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [COUNT_W-1:0]   iter_count;
    logic                 pix_valid;
    logic [COLOR_W-1:0]   pix_color;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // local copy of the palette registers
    logic [COUNT_W-1:0]   limit_reg;
    logic [ORDER_W-1:0]   order_reg;

    logic [COLOR_W-1:0]   expected_colors[$];
    int                   colors_checked;
    int                   color_errors;
    int                   settings_used;
    int                   idle_cycles;
    int                   burst_left;

    iteration_palette_color dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .start             (start),
        .busy              (busy),
        .i_iteration_count (iter_count),
        .o_valid           (pix_valid),
        .o_pixel_color     (pix_color),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // bernstein palette for one count under the current registers
    function automatic logic [COLOR_W-1:0] palette_color(input logic [COUNT_W-1:0] cnt);
        logic [63:0] one_fx, lim, c, t, u, t2, t3, u2, u3, r, g, b;
        logic [7:0]  rb, gb, bb;
        one_fx = 64'd1 << FRAC;
        lim    = 64'(limit_reg);
        c      = 64'(cnt);
        if (lim == 0) begin
            t = 0;
        end else begin
            if (c > lim) c = lim;
            t = (c << FRAC) / lim;
        end
        if (t > one_fx) t = one_fx;
        u  = one_fx - t;
        t2 = (t * t) >> FRAC;
        t3 = (t2 * t) >> FRAC;
        u2 = (u * u) >> FRAC;
        u3 = (u2 * u) >> FRAC;
        r  = (64'(COEF_RED) * ((u * t3) >> FRAC)) >> FRAC;
        g  = (64'(COEF_GREEN) * ((u2 * t2) >> FRAC)) >> FRAC;
        // blue weight is stored doubled, hence the extra shift
        b  = (64'(COEF_BLUE) * ((u3 * t) >> FRAC)) >> (FRAC + 1);
        rb = (r > 255) ? 8'hFF : r[7:0];
        gb = (g > 255) ? 8'hFF : g[7:0];
        bb = (b > 255) ? 8'hFF : b[7:0];
        case (order_reg)
            ORDER_GBR: return {gb, bb, rb};
            ORDER_BRG: return {bb, rb, gb};
            ORDER_RBG: return {rb, bb, gb};
            ORDER_GRB: return {gb, rb, bb};
            ORDER_BGR: return {bb, gb, rb};
            default:   return {rb, gb, bb};
        endcase
    endfunction

    // one count transfer; the expectation is queued on acceptance
    task automatic send_count(input logic [COUNT_W-1:0] cnt);
        start      <= 1'b1;
        iter_count <= cnt;
        do @(posedge clk); while (busy);
        expected_colors.push_back(palette_color(cnt));
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // wait for every pending color, then let the pipeline settle
    task automatic drain;
        start <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_LIMIT) limit_reg = data;
        else order_reg = data[ORDER_W-1:0];
    endtask

    // new setting, with random junk above the order code
    task automatic set_palette(input logic [COUNT_W-1:0] lim, input logic [ORDER_W-1:0] ord);
        drain();
        write_reg(REG_LIMIT, lim);
        write_reg(REG_ORDER, {13'($urandom_range(0, 8191)), ord});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // reset values: limit 100, rgb order
    task automatic test_reset_defaults;
        send_count(16'd0);
        send_count(16'd50);
        send_count(16'd100);
        send_count(16'd101);
        send_count(16'hFFFF);
    endtask

    // extreme limits including zero, counts around and above the limit
    task automatic test_limit_extremes;
        set_palette(16'd1, ORDER_RGB);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'd2);
        send_count(16'hFFFF);
        set_palette(16'hFFFF, ORDER_RGB);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'h8000);
        send_count(16'hFFFE);
        send_count(16'hFFFF);
        set_palette(16'd0, ORDER_RGB);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'hFFFF);
    endtask

    // every channel order code, unused ones fall back to rgb
    task automatic test_channel_orders;
        for (int ord = 0; ord < 8; ord++) begin
            set_palette(16'd4, ORDER_W'(ord));
            send_count(16'd2);
        end
    endtask

    // random settings, bursts of random counts with random gaps
    task automatic test_random_pixels(input int phases, input int per_phase);
        logic [COUNT_W-1:0] lim;
        for (int p = 0; p < phases; p++) begin
            if (p == 0) lim = 16'd1;
            else if (p == 1) lim = 16'hFFFF;
            else if ($urandom_range(0, 1) == 0) lim = 16'($urandom_range(1, 400));
            else lim = 16'($urandom_range(1, 65535));
            set_palette(lim, ORDER_W'($urandom_range(0, 7)));
            burst_left = 0;
            for (int k = 0; k < per_phase; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
                end
                burst_left--;
                if ($urandom_range(0, 3) != 0) send_count(16'($urandom_range(0, lim)));
                else send_count(16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // result check and idle watchdog
    always @(posedge clk) begin
        if (rst_n && pix_valid) begin
            if (expected_colors.size() == 0) begin
                color_errors++;
                if (color_errors <= SHOW_MAX)
                    $display("unexpected color %06h with nothing pending", pix_color);
            end else begin
                logic [COLOR_W-1:0] want;
                want = expected_colors.pop_front();
                colors_checked++;
                if (pix_color !== want) begin
                    color_errors++;
                    if (color_errors <= SHOW_MAX)
                        $display("color mismatch: expected %06h actual %06h", want, pix_color);
                end
            end
        end
        if ((start && !busy) || pix_valid || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        iter_count     <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        limit_reg      = LIMIT_RST;
        order_reg      = ORDER_RST;
        colors_checked = 0;
        color_errors   = 0;
        settings_used  = 1;
        idle_cycles    = 0;
        burst_left     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_limit_extremes();
        test_channel_orders();
        test_random_pixels(8, 82);
        drain();

        // leftover expectations are failures too
        if (expected_colors.size() != 0) begin
            color_errors += expected_colors.size();
            $display("%0d colors never arrived", expected_colors.size());
        end
        $display("checked %0d pixel colors across %0d palette settings", colors_checked,
                 settings_used);
        $display("limits 0, 1, 65535 and random, all eight order codes, %0d mismatches",
                 color_errors);
        if (color_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
